>>> rtl/core/ccir_pkg.sv
package ccir_pkg;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic [30:0]        a_mass;
    logic [30:0]        a_radius;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [30:0]        b_mass;
    logic [30:0]        b_radius;
  } ccir_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] new_a_pos_x;
    logic signed [31:0] new_a_pos_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_pos_x;
    logic signed [31:0] new_b_pos_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic               a_grounded;
    logic               b_grounded;
  } ccir_out_t;

  typedef enum logic [0:0] {
    REG_FLOOR_HEIGHT = 1'b0,
    REG_REST_LIMIT   = 1'b1
  } ccir_reg_e;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_SEP  = 2'd1;
  localparam logic [1:0] ST_HIT  = 2'd2;

  localparam logic [30:0] FLOOR_RESET = 31'd39321600;
  localparam logic [30:0] REST_RESET  = 31'd6554;
  localparam logic [34:0] SLOP_RAW    = 35'd655;
  localparam logic [3:0]  DIV_TEN     = 4'd10;
  localparam logic [3:0]  DIV_FIVE    = 4'd5;

  // pipeline stage map: each transform turns stage t into stage t+1
  localparam int T_MUL  = 0;
  localparam int T_SUM  = 1;
  localparam int T_SQRT = 2;
  localparam int SQRT_N = 33;
  localparam int T_NDIV = 35;
  localparam int DIV_N  = 25;
  localparam int T_DOTM = 60;
  localparam int T_DOT  = 61;
  localparam int T_VN   = 62;
  localparam int T_M17  = 63;
  localparam int T_KDIV = 64;
  localparam int KDIV_N = 8;
  localparam int T_KM   = 72;
  localparam int T_NM   = 73;
  localparam int T_NT   = 74;
  localparam int T_ADD  = 75;
  localparam int T_OUT  = 76;
  localparam int NSTG   = 78;

  typedef struct packed {
    ccir_in_t           src;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic signed [32:0] pay_ra;
    logic signed [32:0] pby_rb;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic [31:0]        mind;
    logic [31:0]        msum;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic               pre;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [65:0]        sqv;
    logic [36:0]        rem;
    logic [32:0]        root;
    logic [31:0]        far;
    logic [31:0]        fbr;
    logic [24:0]        fa;
    logic [24:0]        fb;
    logic               contact;
    logic [31:0]        nxr;
    logic [31:0]        nyr;
    logic [24:0]        nxq;
    logic [24:0]        nyq;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    logic signed [58:0] px;
    logic signed [58:0] py;
    logic signed [59:0] dot;
    logic               sep;
    logic               kneg;
    logic [35:0]        vmag;
    logic [39:0]        m17;
    logic [39:0]        oc4;
    logic [39:0]        kq;
    logic [39:0]        cq;
    logic [3:0]         kr;
    logic [3:0]         cr;
    logic [58:0]        pka;
    logic [58:0]        pkb;
    logic [58:0]        pca;
    logic [58:0]        pcb;
    logic [59:0]        tax;
    logic [59:0]        tay;
    logic [59:0]        tbx;
    logic [59:0]        tby;
    logic [59:0]        tcax;
    logic [59:0]        tcay;
    logic [59:0]        tcbx;
    logic [59:0]        tcby;
    logic signed [36:0] dvax;
    logic signed [36:0] dvay;
    logic signed [36:0] dvbx;
    logic signed [36:0] dvby;
    logic signed [36:0] dpax;
    logic signed [36:0] dpay;
    logic signed [36:0] dpbx;
    logic signed [36:0] dpby;
    ccir_out_t          res;
  } ctx_t;

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (v > 38'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'h8000_0000;
    end
    return r;
  endfunction

  function automatic logic signed [36:0] sgn37(input logic [35:0] m, input logic neg);
    logic signed [36:0] e;
    e = $signed({1'b0, m});
    return neg ? -e : e;
  endfunction

  function automatic logic signed [37:0] add38(input logic signed [31:0] b,
                                               input logic signed [36:0] d);
    return 38'(b) + 38'(d);
  endfunction

  // five quotient bits of a division by a small constant, remainder in r
  function automatic logic [8:0] cdiv_chunk(input logic [3:0] r, input logic [4:0] nb,
                                            input logic [3:0] dv);
    logic [4:0] t;
    logic [3:0] rr;
    logic [4:0] q;
    rr = r;
    q  = '0;
    for (int i = 4; i >= 0; i--) begin
      t = {rr, nb[i]};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[i] = 1'b1;
      end
      rr = t[3:0];
    end
    return {rr, q};
  endfunction

  // one restoring division step, returns new remainder and quotient bit
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic        q;
    t = {r, nb};
    q = 1'b0;
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      q = 1'b1;
    end
    return {t[31:0], q};
  endfunction

endpackage

>>> rtl/core/circle_collision_impulse_resolve_core.sv
// throughput: one transaction per cycle while the output is not stalled;
// the sqrt (33 stages, one root bit each) and the normal divide (25 stages,
// one quotient bit each) set the depth
// a stalled output holds the whole pipeline; input stall follows output stall
// reset clears valid bits and loads the floor height and rest speed limit defaults
module circle_collision_impulse_resolve_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ccir_pkg::ccir_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ccir_pkg::ccir_out_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int LAST = ccir_pkg::NSTG - 1;

  logic [30:0] floor_q;
  logic [30:0] rest_q;
  logic        adv;
  logic [ccir_pkg::NSTG-1:0] vld_q;
  ccir_pkg::ctx_t ctx_in;
  ccir_pkg::ctx_t ctx_q [ccir_pkg::NSTG];
  ccir_pkg::ctx_t ctx_d [ccir_pkg::NSTG-1];

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= ccir_pkg::FLOOR_RESET;
      rest_q  <= ccir_pkg::REST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ccir_pkg::ccir_reg_e'(paddr[2]))
        ccir_pkg::REG_FLOOR_HEIGHT: floor_q <= pwdata[30:0];
        ccir_pkg::REG_REST_LIMIT:   rest_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ccir_pkg::ccir_reg_e'(paddr[2]))
      ccir_pkg::REG_FLOOR_HEIGHT: prdata = {1'b0, floor_q};
      ccir_pkg::REG_REST_LIMIT:   prdata = {1'b0, rest_q};
      default:                    prdata = '0;
    endcase
  end

  // global advance
  assign adv         = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAST];
  assign out_data_o  = ctx_q[LAST].res;

  // entry stage
  always_comb begin
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic [32:0]        mx;
    logic [32:0]        my;
    ctx_in     = '0;
    ctx_in.src = in_data_i;
    ax = 33'(in_data_i.b_pos_x) - 33'(in_data_i.a_pos_x);
    ay = 33'(in_data_i.b_pos_y) - 33'(in_data_i.a_pos_y);
    mx = ax[32] ? 33'(-ax) : 33'(ax);
    my = ay[32] ? 33'(-ay) : 33'(ay);
    ctx_in.dx     = ax;
    ctx_in.dy     = ay;
    ctx_in.ux     = mx[31:0];
    ctx_in.uy     = my[31:0];
    ctx_in.mind   = {1'b0, in_data_i.a_radius} + {1'b0, in_data_i.b_radius};
    ctx_in.pre    = (ctx_in.mind != '0) && (mx < {1'b0, ctx_in.mind}) &&
                    (my < {1'b0, ctx_in.mind});
    ctx_in.rvx    = 33'(in_data_i.b_vel_x) - 33'(in_data_i.a_vel_x);
    ctx_in.rvy    = 33'(in_data_i.b_vel_y) - 33'(in_data_i.a_vel_y);
    ctx_in.pay_ra = 33'(in_data_i.a_pos_y) + $signed({2'b00, in_data_i.a_radius});
    ctx_in.pby_rb = 33'(in_data_i.b_pos_y) + $signed({2'b00, in_data_i.b_radius});
    ctx_in.ma     = (in_data_i.a_mass == '0) ? 31'd1 : in_data_i.a_mass;
    ctx_in.mb     = (in_data_i.b_mass == '0) ? 31'd1 : in_data_i.b_mass;
    ctx_in.msum   = {1'b0, ctx_in.ma} + {1'b0, ctx_in.mb};
  end

  // squares
  always_comb begin
    ctx_d[ccir_pkg::T_MUL]     = ctx_q[ccir_pkg::T_MUL];
    ctx_d[ccir_pkg::T_MUL].sqx = 64'(ctx_q[ccir_pkg::T_MUL].ux) *
                                 64'(ctx_q[ccir_pkg::T_MUL].ux);
    ctx_d[ccir_pkg::T_MUL].sqy = 64'(ctx_q[ccir_pkg::T_MUL].uy) *
                                 64'(ctx_q[ccir_pkg::T_MUL].uy);
  end

  always_comb begin
    ctx_d[ccir_pkg::T_SUM]     = ctx_q[ccir_pkg::T_SUM];
    ctx_d[ccir_pkg::T_SUM].sqv = {1'b0, 65'(ctx_q[ccir_pkg::T_SUM].sqx) +
                                        65'(ctx_q[ccir_pkg::T_SUM].sqy)};
  end

  // square root, one bit per stage, with the mass ratio divides alongside
  for (genvar j = 0; j < ccir_pkg::SQRT_N; j++) begin : g_sqrt
    always_comb begin
      ccir_pkg::ctx_t c;
      logic [36:0] r;
      logic [32:0] rt;
      logic [36:0] tst;
      logic [32:0] sa;
      logic [32:0] sb;
      c  = ctx_q[ccir_pkg::T_SQRT+j];
      r  = (j == 0) ? '0 : c.rem;
      rt = (j == 0) ? '0 : c.root;
      r  = {r[34:0], c.sqv[2*(32-j)+1 -: 2]};
      rt = {rt[31:0], 1'b0};
      tst = {3'b000, rt, 1'b1};
      if (r >= tst) begin
        r     = r - tst;
        rt[0] = 1'b1;
      end
      c.rem  = r;
      c.root = rt;
      if (j < ccir_pkg::DIV_N) begin
        if (j == 0) begin
          c.fa  = '0;
          c.fb  = '0;
          c.far = {1'b0, c.mb[30:1]};
          c.fbr = {1'b0, c.ma[30:1]};
        end
        sa = ccir_pkg::div_step(c.far, (j == 0) ? c.mb[0] : 1'b0, c.msum);
        sb = ccir_pkg::div_step(c.fbr, (j == 0) ? c.ma[0] : 1'b0, c.msum);
        c.far = sa[32:1];
        c.fbr = sb[32:1];
        c.fa[ccir_pkg::DIV_N-1-j] = sa[0];
        c.fb[ccir_pkg::DIV_N-1-j] = sb[0];
      end
      ctx_d[ccir_pkg::T_SQRT+j] = c;
    end
  end

  // contact normal, one quotient bit per stage
  for (genvar j = 0; j < ccir_pkg::DIV_N; j++) begin : g_ndiv
    always_comb begin
      ccir_pkg::ctx_t c;
      logic [32:0] sx;
      logic [32:0] sy;
      c = ctx_q[ccir_pkg::T_NDIV+j];
      if (j == 0) begin
        c.contact = (c.root != '0) && (c.root < {1'b0, c.mind});
        c.nxq     = '0;
        c.nyq     = '0;
        c.nxr     = {1'b0, c.ux[31:1]};
        c.nyr     = {1'b0, c.uy[31:1]};
      end
      sx = ccir_pkg::div_step(c.nxr, (j == 0) ? c.ux[0] : 1'b0, c.root[31:0]);
      sy = ccir_pkg::div_step(c.nyr, (j == 0) ? c.uy[0] : 1'b0, c.root[31:0]);
      c.nxr = sx[32:1];
      c.nyr = sy[32:1];
      c.nxq[ccir_pkg::DIV_N-1-j] = sx[0];
      c.nyq[ccir_pkg::DIV_N-1-j] = sy[0];
      if (j == ccir_pkg::DIV_N - 1) begin
        c.nx = c.dx[32] ? -$signed({1'b0, c.nxq}) : $signed({1'b0, c.nxq});
        c.ny = c.dy[32] ? -$signed({1'b0, c.nyq}) : $signed({1'b0, c.nyq});
      end
      ctx_d[ccir_pkg::T_NDIV+j] = c;
    end
  end

  // relative velocity along the normal
  always_comb begin
    ctx_d[ccir_pkg::T_DOTM]    = ctx_q[ccir_pkg::T_DOTM];
    ctx_d[ccir_pkg::T_DOTM].px = 59'($signed(ctx_q[ccir_pkg::T_DOTM].rvx)) *
                                 59'($signed(ctx_q[ccir_pkg::T_DOTM].nx));
    ctx_d[ccir_pkg::T_DOTM].py = 59'($signed(ctx_q[ccir_pkg::T_DOTM].rvy)) *
                                 59'($signed(ctx_q[ccir_pkg::T_DOTM].ny));
  end

  always_comb begin
    ctx_d[ccir_pkg::T_DOT]     = ctx_q[ccir_pkg::T_DOT];
    ctx_d[ccir_pkg::T_DOT].dot = 60'($signed(ctx_q[ccir_pkg::T_DOT].px)) +
                                 60'($signed(ctx_q[ccir_pkg::T_DOT].py));
  end

  always_comb begin
    ccir_pkg::ctx_t c;
    logic signed [59:0] ad;
    c      = ctx_q[ccir_pkg::T_VN];
    ad     = c.dot[59] ? -c.dot : c.dot;
    c.vmag = ad[59:24];
    c.kneg = c.dot[59];
    c.sep  = !c.dot[59] && (c.dot != '0);
    ctx_d[ccir_pkg::T_VN] = c;
  end

  always_comb begin
    ccir_pkg::ctx_t c;
    logic signed [34:0] ov;
    c     = ctx_q[ccir_pkg::T_M17];
    c.m17 = {c.vmag, 4'b0000} + {4'b0000, c.vmag};
    ov    = $signed({3'b000, c.mind}) - $signed({2'b00, c.root}) -
            $signed(ccir_pkg::SLOP_RAW);
    if (ov[34]) begin
      ov = '0;
    end
    c.oc4 = {5'b00000, ov[32:0], 2'b00};
    ctx_d[ccir_pkg::T_M17] = c;
  end

  // restitution scale /10 and correction scale /5, five bits per stage
  for (genvar j = 0; j < ccir_pkg::KDIV_N; j++) begin : g_kdiv
    always_comb begin
      ccir_pkg::ctx_t c;
      logic [8:0] rk;
      logic [8:0] rc;
      c = ctx_q[ccir_pkg::T_KDIV+j];
      if (j == 0) begin
        c.kr = '0;
        c.cr = '0;
      end
      rk = ccir_pkg::cdiv_chunk(c.kr, c.m17[39-5*j -: 5], ccir_pkg::DIV_TEN);
      rc = ccir_pkg::cdiv_chunk(c.cr, c.oc4[39-5*j -: 5], ccir_pkg::DIV_FIVE);
      c.kr = rk[8:5];
      c.cr = rc[8:5];
      c.kq[39-5*j -: 5] = rk[4:0];
      c.cq[39-5*j -: 5] = rc[4:0];
      ctx_d[ccir_pkg::T_KDIV+j] = c;
    end
  end

  // mass weighting
  always_comb begin
    ccir_pkg::ctx_t c;
    c     = ctx_q[ccir_pkg::T_KM];
    c.pka = 59'(c.kq[33:0]) * 59'(c.fa);
    c.pkb = 59'(c.kq[33:0]) * 59'(c.fb);
    c.pca = 59'(c.cq[33:0]) * 59'(c.fa);
    c.pcb = 59'(c.cq[33:0]) * 59'(c.fb);
    ctx_d[ccir_pkg::T_KM] = c;
  end

  // projection onto the normal
  always_comb begin
    ccir_pkg::ctx_t c;
    c      = ctx_q[ccir_pkg::T_NM];
    c.tax  = 60'(c.pka[58:24]) * 60'(c.nxq);
    c.tay  = 60'(c.pka[58:24]) * 60'(c.nyq);
    c.tbx  = 60'(c.pkb[58:24]) * 60'(c.nxq);
    c.tby  = 60'(c.pkb[58:24]) * 60'(c.nyq);
    c.tcax = 60'(c.pca[58:24]) * 60'(c.nxq);
    c.tcay = 60'(c.pca[58:24]) * 60'(c.nyq);
    c.tcbx = 60'(c.pcb[58:24]) * 60'(c.nxq);
    c.tcby = 60'(c.pcb[58:24]) * 60'(c.nyq);
    ctx_d[ccir_pkg::T_NM] = c;
  end

  always_comb begin
    ccir_pkg::ctx_t c;
    logic sgx;
    logic sgy;
    c    = ctx_q[ccir_pkg::T_NT];
    sgx  = c.kneg ^ c.dx[32];
    sgy  = c.kneg ^ c.dy[32];
    c.dvax = ccir_pkg::sgn37(c.tax[59:24], sgx);
    c.dvay = ccir_pkg::sgn37(c.tay[59:24], sgy);
    c.dvbx = ccir_pkg::sgn37(c.tbx[59:24], !sgx);
    c.dvby = ccir_pkg::sgn37(c.tby[59:24], !sgy);
    c.dpax = ccir_pkg::sgn37(c.tcax[59:24], !c.dx[32]);
    c.dpay = ccir_pkg::sgn37(c.tcay[59:24], !c.dy[32]);
    c.dpbx = ccir_pkg::sgn37(c.tcbx[59:24], c.dx[32]);
    c.dpby = ccir_pkg::sgn37(c.tcby[59:24], c.dy[32]);
    ctx_d[ccir_pkg::T_NT] = c;
  end

  always_comb begin
    ccir_pkg::ctx_t c;
    c = ctx_q[ccir_pkg::T_ADD];
    c.res.new_a_pos_x = ccir_pkg::sat32(ccir_pkg::add38(c.src.a_pos_x, c.dpax));
    c.res.new_a_pos_y = ccir_pkg::sat32(ccir_pkg::add38(c.src.a_pos_y, c.dpay));
    c.res.new_a_vel_x = ccir_pkg::sat32(ccir_pkg::add38(c.src.a_vel_x, c.dvax));
    c.res.new_a_vel_y = ccir_pkg::sat32(ccir_pkg::add38(c.src.a_vel_y, c.dvay));
    c.res.new_b_pos_x = ccir_pkg::sat32(ccir_pkg::add38(c.src.b_pos_x, c.dpbx));
    c.res.new_b_pos_y = ccir_pkg::sat32(ccir_pkg::add38(c.src.b_pos_y, c.dpby));
    c.res.new_b_vel_x = ccir_pkg::sat32(ccir_pkg::add38(c.src.b_vel_x, c.dvbx));
    c.res.new_b_vel_y = ccir_pkg::sat32(ccir_pkg::add38(c.src.b_vel_y, c.dvby));
    ctx_d[ccir_pkg::T_ADD] = c;
  end

  // grounded test and result select
  always_comb begin
    ccir_pkg::ctx_t c;
    logic [32:0] mva;
    logic [32:0] mvb;
    logic        ga;
    logic        gb;
    c   = ctx_q[ccir_pkg::T_OUT];
    mva = c.res.new_a_vel_y[31] ? 33'(-33'(c.res.new_a_vel_y)) :
                                  {1'b0, c.res.new_a_vel_y};
    mvb = c.res.new_b_vel_y[31] ? 33'(-33'(c.res.new_b_vel_y)) :
                                  {1'b0, c.res.new_b_vel_y};
    ga  = (mva < {2'b00, rest_q}) && (c.pay_ra >= $signed({2'b00, floor_q}));
    gb  = (mvb < {2'b00, rest_q}) && (c.pby_rb >= $signed({2'b00, floor_q}));
    if (c.pre && c.contact && !c.sep) begin
      c.res.status     = ccir_pkg::ST_HIT;
      c.res.a_grounded = ga;
      c.res.b_grounded = gb;
    end else begin
      c.res.status      = (c.pre && c.contact) ? ccir_pkg::ST_SEP : ccir_pkg::ST_NONE;
      c.res.new_a_pos_x = c.src.a_pos_x;
      c.res.new_a_pos_y = c.src.a_pos_y;
      c.res.new_a_vel_x = c.src.a_vel_x;
      c.res.new_a_vel_y = c.src.a_vel_y;
      c.res.new_b_pos_x = c.src.b_pos_x;
      c.res.new_b_pos_y = c.src.b_pos_y;
      c.res.new_b_vel_x = c.src.b_vel_x;
      c.res.new_b_vel_y = c.src.b_vel_y;
      c.res.a_grounded  = 1'b0;
      c.res.b_grounded  = 1'b0;
    end
    ctx_d[ccir_pkg::T_OUT] = c;
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ccir_pkg::NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0] <= ctx_in;
      for (int t = 0; t < ccir_pkg::NSTG - 1; t++) begin
        ctx_q[t+1] <= ctx_d[t];
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction lost at entry");

  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while held");

  a_grounded_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ccir_pkg::ST_HIT)) |->
    (!out_data_o.a_grounded && !out_data_o.b_grounded))
    else $error("grounded flag without resolved collision");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ccir_pkg::ST_NONE)) |->
    (out_data_o.new_b_vel_y == ctx_q[LAST].src.b_vel_y))
    else $error("body changed without contact");
`endif

endmodule
